// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types and constants for the text console writer
// holds the action codes, sequencer states, field widths and default sizes
// no dependencies
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // port field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int INDEX_W  = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // control bytes
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;

    // attribute after reset: light grey on black
    localparam logic [ATTR_W-1:0] COLOR_RST = 8'h07;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } t_state;

endpackage

// ===== src/tcw_cell_ram.sv =====
// tcw_cell_ram: screen store, one write port and one registered read port
// used by text_console_writer_core; no package dependencies
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/text_console_writer_core.sv =====
// text_console_writer_core: character-cell text console with cursor and screen store
// depends on tcw_pkg and tcw_cell_ram
//
// Usage
//   Input channel (i_valid / o_ready) carries one item: action, char_code, row, col.
//   Output channel (o_valid / i_ready) returns one result per item: cursor row,
//   column and linear index (row * COLUMNS + col), plus the cell for a read.
//   i_cfg_we / i_cfg_wdata write the attribute byte used for new and blanked cells.
// Sequence per item, from accept until the block is ready again:
//   the result becomes valid in the same cycle that the block is ready again
//   carriage return, line feed, ordinary character, set cursor: accept, then done
//   read cell: accept, then the registered store read, then done
//   clear screen: accept, a blank pass over every cell, one cell write per cycle, then done
//   a put that runs past the bottom row adds a scroll pass before done: the copy of
//   rows up by one and the bottom row blank go through the store's write port,
//   one cell a cycle, under one address counter
//   The block handles one item at a time; o_ready is high only when it is idle.
// Reset clears the cursor to (0,0) and the attribute to 7; the screen store is
//   undefined until the first clear.
// A stalled receiver holds the result in the output register; the next item is
//   still taken and waits in its final state until the register is free.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tcw_pkg::ACTION_W-1:0] i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]    i_row,
    input  logic [tcw_pkg::COL_W-1:0]    i_col,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tcw_pkg::INDEX_W-1:0]  o_cursor_index,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] BLANK_FIRST = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
    localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

    // registers
    tcw_pkg::t_state                r_state, n_state;
    logic [tcw_pkg::ATTR_W-1:0]     r_text_color;
    logic [RW-1:0]                  r_cur_row, n_cur_row;
    logic [CW-1:0]                  r_cur_col, n_cur_col;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [tcw_pkg::CHAR_W-1:0]     r_cell_char, n_cell_char;
    logic [tcw_pkg::ATTR_W-1:0]     r_cell_attr, n_cell_attr;
    logic                           r_out_valid, n_out_valid;
    logic [tcw_pkg::ROW_W-1:0]      r_o_row, n_o_row;
    logic [tcw_pkg::COL_W-1:0]      r_o_col, n_o_col;
    logic [tcw_pkg::INDEX_W-1:0]    r_o_idx, n_o_idx;
    logic [tcw_pkg::CHAR_W-1:0]     r_o_char, n_o_char;
    logic [tcw_pkg::ATTR_W-1:0]     r_o_attr, n_o_attr;

    // store port signals
    logic                           w_mem_we;
    logic [AW-1:0]                  w_mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]     w_mem_wdata;
    logic [AW-1:0]                  w_mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]     w_mem_rdata;

    // decode helpers
    tcw_pkg::t_action               w_action;
    logic                           w_in_acc;
    logic                           w_out_free;
    logic [RW-1:0]                  w_row_clamp;
    logic [CW-1:0]                  w_col_clamp;
    logic [AW-1:0]                  w_cur_idx;
    logic [AW-1:0]                  w_req_idx;
    logic                           w_is_cr;
    logic                           w_is_lf;
    logic                           w_at_eol;
    logic                           w_at_last;
    logic                           w_line_adv;
    logic                           w_put_scroll;
    logic [tcw_pkg::CELL_W-1:0]     w_blank;

    assign w_action   = tcw_pkg::t_action'(i_action);
    assign o_ready    = (r_state == tcw_pkg::ST_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // clamp requested position to the screen
    assign w_row_clamp = (int'(i_row) > ROWS - 1) ? ROW_LAST : RW'(i_row);
    assign w_col_clamp = (int'(i_col) > COLUMNS - 1) ? COL_LAST : CW'(i_col);

    // linear cell indexes
    assign w_cur_idx = AW'(r_cur_row * COLS_A) + AW'(r_cur_col);
    assign w_req_idx = AW'(w_row_clamp * COLS_A) + AW'(w_col_clamp);

    // put-char line handling
    assign w_is_cr      = (i_char_code == tcw_pkg::CH_CR);
    assign w_is_lf      = (i_char_code == tcw_pkg::CH_LF);
    assign w_at_eol     = (r_cur_col == COL_LAST);
    assign w_at_last    = (r_cur_row == ROW_LAST);
    assign w_line_adv   = w_is_lf || (!w_is_cr && w_at_eol);
    assign w_put_scroll = w_line_adv && w_at_last;

    assign w_blank = {r_text_color, tcw_pkg::CHAR_W'(0)};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_action)
                        tcw_pkg::ACT_PUT:
                            n_state = w_put_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
                        tcw_pkg::ACT_SET:   n_state = tcw_pkg::ST_DONE;
                        tcw_pkg::ACT_CLEAR: n_state = tcw_pkg::ST_BLANK;
                        tcw_pkg::ACT_READ:  n_state = tcw_pkg::ST_READ;
                    endcase
                end
            end
            tcw_pkg::ST_READ:   n_state = tcw_pkg::ST_DONE;
            tcw_pkg::ST_SCROLL: begin
                if (r_addr == SCROLL_LAST) begin
                    n_state = tcw_pkg::ST_BLANK;
                end
            end
            tcw_pkg::ST_BLANK: begin
                if (r_addr == CELL_LAST) begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_addr      = r_addr;
        n_cell_char = r_cell_char;
        n_cell_attr = r_cell_attr;
        n_out_valid = r_out_valid && !i_ready;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_idx     = r_o_idx;
        n_o_char    = r_o_char;
        n_o_attr    = r_o_attr;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = w_blank;
        // read ahead by one row plus one cell during the scroll copy
        w_mem_raddr = AW'(r_addr + COLS_A + 1'b1);

        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_cell_char = '0;
                    n_cell_attr = '0;
                    n_addr      = '0;
                    unique case (w_action)
                        tcw_pkg::ACT_PUT: begin
                            // first read of a possible scroll copy
                            w_mem_raddr = COLS_A;
                            if (!w_is_cr && !w_is_lf) begin
                                w_mem_we    = 1'b1;
                                w_mem_waddr = w_cur_idx;
                                w_mem_wdata = {r_text_color, i_char_code};
                            end
                            if (w_line_adv || w_is_cr) begin
                                n_cur_col = '0;
                            end else begin
                                n_cur_col = CW'(r_cur_col + 1'b1);
                            end
                            if (w_line_adv && !w_at_last) begin
                                n_cur_row = RW'(r_cur_row + 1'b1);
                            end
                        end
                        tcw_pkg::ACT_SET: begin
                            n_cur_row = w_row_clamp;
                            n_cur_col = w_col_clamp;
                        end
                        tcw_pkg::ACT_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                        end
                        tcw_pkg::ACT_READ: begin
                            w_mem_raddr = w_req_idx;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                n_cell_char = w_mem_rdata[tcw_pkg::CHAR_W-1:0];
                n_cell_attr = w_mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            tcw_pkg::ST_SCROLL: begin
                // move one cell up a row
                w_mem_we    = 1'b1;
                w_mem_wdata = w_mem_rdata;
                n_addr      = (r_addr == SCROLL_LAST) ? BLANK_FIRST : AW'(r_addr + 1'b1);
            end
            tcw_pkg::ST_BLANK: begin
                w_mem_we = 1'b1;
                n_addr   = AW'(r_addr + 1'b1);
            end
            tcw_pkg::ST_DONE: begin
                // load result once the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_row     = tcw_pkg::ROW_W'(r_cur_row);
                    n_o_col     = tcw_pkg::COL_W'(r_cur_col);
                    n_o_idx     = tcw_pkg::INDEX_W'(w_cur_idx);
                    n_o_char    = r_cell_char;
                    n_o_attr    = r_cell_attr;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcw_pkg::ST_IDLE;
            r_text_color <= tcw_pkg::COLOR_RST;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_cell_char <= n_cell_char;
        r_cell_attr <= n_cell_attr;
        r_o_row     <= n_o_row;
        r_o_col     <= n_o_col;
        r_o_idx     <= n_o_idx;
        r_o_char    <= n_o_char;
        r_o_attr    <= n_o_attr;
    end

    // screen store
    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (tcw_pkg::CELL_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_cursor_row   = r_o_row;
    assign o_cursor_col   = r_o_col;
    assign o_cursor_index = r_o_idx;
    assign o_cell_char    = r_o_char;
    assign o_cell_attr    = r_o_attr;

    // cursor always on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur_row) < ROWS) && (int'(r_cur_col) < COLUMNS))
        else $error("cursor left the screen");

    // scroll copy never runs past its last source row
    a_scroll_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_SCROLL) |-> (r_addr <= SCROLL_LAST))
        else $error("scroll address out of range");

    // blank pass keeps going until the last cell
    a_blank_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_BLANK && r_addr != CELL_LAST)
        |=> (r_state == tcw_pkg::ST_BLANK))
        else $error("blank pass ended early");

    // a read item goes through the store read state
    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_action == tcw_pkg::ACT_READ) |=> (r_state == tcw_pkg::ST_READ))
        else $error("read item skipped the store read");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_DONE && r_out_valid && !i_ready)
        |=> (r_state == tcw_pkg::ST_DONE && r_out_valid))
        else $error("pending result overwritten");

endmodule
